[hw/rtl/lspe_pkg.sv]
// ============================================================================
// LCG seed preimage search: shared package
// Generator constants, queue entry and status types, and state encodings.
// ============================================================================
package lspe_pkg;

    // Forward generator x' = x * FWD_MUL + FWD_ADD (mod 2^32) and its inverse.
    localparam logic [31:0] FWD_MUL = 32'h0003_43FD;
    localparam logic [31:0] FWD_ADD = 32'h0026_9EC3;
    localparam logic [31:0] INV_MUL = 32'hB9B3_3155;
    localparam logic [31:0] INV_ADD = 32'hA170_F641;

    localparam logic [11:0] BACK_STEPS_RESET = 12'd1100;
    localparam logic [15:0] SCAN_LAST        = 16'hFFFF;

    // Queue between the scanner and the rewind engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One queue entry: a matching seed, or the mark that a scan has ended.
    typedef struct packed {
        logic        is_end;
        logic [31:0] seed;
    } queue_entry_t;

    typedef struct packed {
        logic         push;
        queue_entry_t entry;
    } queue_wr_t;

    typedef struct packed {
        logic         empty;
        logic         full;
        queue_entry_t head;
    } queue_stat_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_SCAN,
        FRONT_FLUSH
    } front_state_t;

    typedef enum logic {
        BACK_WAIT,
        BACK_REWIND
    } back_state_t;

endpackage

[hw/rtl/lspe_if.sv]
// ============================================================================
// LCG seed preimage search: channel interfaces
// Valid/ready channels for search requests and for search results.
// ============================================================================
interface lspe_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_high;
    logic [15:0] next_high;

    modport source (output valid, output first_high, output next_high, input ready);
    modport sink   (input valid, input first_high, input next_high, output ready);
endinterface

interface lspe_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] seed_value;
    logic [31:0] earlier_seed;
    logic        last;

    modport source (output valid, output found, output seed_value, output earlier_seed,
                    output last, input ready);
    modport sink   (input valid, input found, input seed_value, input earlier_seed,
                    input last, output ready);
endinterface

[hw/rtl/lcg_seed_preimage_search.sv]
// ============================================================================
// LCG seed preimage search: top level
// Finds 32-bit generator seeds from two observed upper halves and rewinds them.
// ============================================================================
// Each search transaction names the upper half of a seed (first_high) and the
// upper half of the state one generator step later (next_high). The block
// tries all 65536 lower halves in increasing order, one per clock while the
// match queue has room; the next search transaction is taken once the scan
// has ended. Every matching seed (at most four) is stepped back back_steps
// times through the inverse generator, one step per cycle in a single
// 32-bit multiply-add loop. Rewinding runs alongside the scan. Matches lie
// about 20000 candidates apart, so each rewind ends before the next match
// turns up; a stalled result consumer delays the completion of a search.
// Results leave in seed order, the final one of each search marked by last; a
// search without any match yields one result with found clear and zero seeds.
// back_steps resets to 1100 and may only be written while the block is idle.
// ============================================================================
module lcg_seed_preimage_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        back_steps_we,
    input  logic [11:0] back_steps_wdata,
    lspe_in_if.sink     search,
    lspe_out_if.source  result
);
    import lspe_pkg::*;

    logic [11:0] back_steps_reg;

    // Handshake between the scanner, the match queue and the rewind engine.
    queue_wr_t   queue_wr;
    queue_stat_t queue_stat;
    logic        queue_pop;

    // Rewind count; the user must write it only between searches, unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_steps_reg <= BACK_STEPS_RESET;
        end
        else if (back_steps_we)
        begin
            back_steps_reg <= back_steps_wdata;
        end
    end

    // The scanner keeps the generator output of the current candidate in a
    // register and adds the multiplier for each next lower half, so no
    // multiplication is needed during the scan.
    lspe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .search (search),
        .stat   (queue_stat),
        .wr     (queue_wr)
    );

    // The queue lets the scanner keep going while a match is being rewound.
    lspe_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (queue_wr),
        .pop   (queue_pop),
        .stat  (queue_stat)
    );

    // The rewind engine owns the result register, which decouples it from a
    // stalled result consumer.
    lspe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .back_steps (back_steps_reg),
        .stat       (queue_stat),
        .pop        (queue_pop),
        .result     (result)
    );

endmodule

[hw/rtl/lspe_fifo.sv]
// ============================================================================
// LCG seed preimage search: match queue
// Small first-in first-out queue of matching seeds and end-of-scan marks.
// ============================================================================
module lspe_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lspe_pkg::queue_wr_t    wr,
    input  logic                   pop,
    output lspe_pkg::queue_stat_t  stat
);
    import lspe_pkg::*;

    queue_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;
    logic [QPTR_W:0]       count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !wr.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.entry;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign stat.head  = mem_reg[rd_ptr_reg];

endmodule

[hw/rtl/lspe_front.sv]
// ============================================================================
// LCG seed preimage search: scanner
// Walks all 65536 lower halves of a request, queueing matches and an end mark.
// ============================================================================
module lspe_front (
    input  logic                   clk,
    input  logic                   rst_n,
    lspe_in_if.sink                search,
    input  lspe_pkg::queue_stat_t  stat,
    output lspe_pkg::queue_wr_t    wr
);
    import lspe_pkg::*;

    front_state_t state_reg;
    front_state_t state_next;

    logic [15:0] hi_reg;
    logic [15:0] want_reg;
    logic [15:0] lo_reg;
    logic [31:0] succ_reg;      // forward step of the current candidate
    logic [31:0] start_succ;
    logic        accept;
    logic        advance;
    logic        match;

    // Successor of {first_high, 16'h0}; later candidates add FWD_MUL each.
    assign start_succ = {search.first_high, 16'h0000} * FWD_MUL + FWD_ADD;
    assign match      = (succ_reg[31:16] == want_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FRONT_IDLE:
            begin
                if (search.valid)
                begin
                    state_next = FRONT_SCAN;
                end
            end
            FRONT_SCAN:
            begin
                if (advance && (lo_reg == SCAN_LAST))
                begin
                    state_next = FRONT_FLUSH;
                end
            end
            FRONT_FLUSH:
            begin
                if (!stat.full)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    always_comb
    begin
        search.ready = 1'b0;
        accept       = 1'b0;
        advance      = 1'b0;
        wr           = '0;
        case (state_reg)
            FRONT_IDLE:
            begin
                search.ready = 1'b1;
                accept       = search.valid;
            end
            FRONT_SCAN:
            begin
                if (!match)
                begin
                    advance = 1'b1;
                end
                else if (!stat.full)
                begin
                    advance        = 1'b1;
                    wr.push        = 1'b1;
                    wr.entry.seed  = {hi_reg, lo_reg};
                end
            end
            FRONT_FLUSH:
            begin
                if (!stat.full)
                begin
                    wr.push         = 1'b1;
                    wr.entry.is_end = 1'b1;
                end
            end
            default:
            begin
                wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hi_reg   <= search.first_high;
            want_reg <= search.next_high;
            lo_reg   <= '0;
            succ_reg <= start_succ;
        end
        else if (advance)
        begin
            lo_reg   <= lo_reg + 1'b1;
            succ_reg <= succ_reg + FWD_MUL;
        end
    end

endmodule

[hw/rtl/lspe_back.sv]
// ============================================================================
// LCG seed preimage search: rewind engine
// Steps each queued seed back through the inverse generator and emits results.
// ============================================================================
module lspe_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [11:0]            back_steps,
    input  lspe_pkg::queue_stat_t  stat,
    output logic                   pop,
    lspe_out_if.source             result
);
    import lspe_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic        held_valid_reg;
    logic [31:0] held_seed_reg;
    logic [31:0] held_earlier_reg;
    logic [31:0] work_seed_reg;
    logic [31:0] rewind_value_reg;
    logic [11:0] rewind_count_reg;

    logic        out_valid_reg;
    logic        out_found_reg;
    logic [31:0] out_seed_reg;
    logic [31:0] out_earlier_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        rewind_done;
    logic        start_rewind;
    logic        finish;
    logic        step;
    logic        load_out;
    logic        load_found;
    logic [31:0] load_seed;
    logic [31:0] load_earlier;
    logic        load_last;

    assign out_free    = !out_valid_reg || result.ready;
    assign rewind_done = (rewind_count_reg == back_steps);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_WAIT:
            begin
                if (start_rewind)
                begin
                    state_next = BACK_REWIND;
                end
            end
            BACK_REWIND:
            begin
                if (rewind_done)
                begin
                    state_next = BACK_WAIT;
                end
            end
            default:
            begin
                state_next = BACK_WAIT;
            end
        endcase
    end

    // A finished match is held until the next queue entry shows whether
    // another match follows or the scan has ended; that sets its last flag.
    always_comb
    begin
        pop          = 1'b0;
        start_rewind = 1'b0;
        finish       = 1'b0;
        step         = 1'b0;
        load_out     = 1'b0;
        load_found   = 1'b0;
        load_seed    = '0;
        load_earlier = '0;
        load_last    = 1'b0;
        case (state_reg)
            BACK_WAIT:
            begin
                if (!stat.empty)
                begin
                    if (stat.head.is_end)
                    begin
                        if (out_free)
                        begin
                            pop        = 1'b1;
                            load_out   = 1'b1;
                            load_last  = 1'b1;
                            load_found = held_valid_reg;
                            if (held_valid_reg)
                            begin
                                load_seed    = held_seed_reg;
                                load_earlier = held_earlier_reg;
                            end
                        end
                    end
                    else if (!held_valid_reg)
                    begin
                        pop          = 1'b1;
                        start_rewind = 1'b1;
                    end
                    else if (out_free)
                    begin
                        pop          = 1'b1;
                        start_rewind = 1'b1;
                        load_out     = 1'b1;
                        load_found   = 1'b1;
                        load_seed    = held_seed_reg;
                        load_earlier = held_earlier_reg;
                    end
                end
            end
            BACK_REWIND:
            begin
                if (rewind_done)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    step = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BACK_WAIT;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                held_valid_reg <= 1'b1;
            end
            else if (load_out)
            begin
                held_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_rewind)
        begin
            work_seed_reg    <= stat.head.seed;
            rewind_value_reg <= stat.head.seed;
            rewind_count_reg <= '0;
        end
        else if (step)
        begin
            rewind_value_reg <= rewind_value_reg * INV_MUL + INV_ADD;
            rewind_count_reg <= rewind_count_reg + 1'b1;
        end
        if (finish)
        begin
            held_seed_reg    <= work_seed_reg;
            held_earlier_reg <= rewind_value_reg;
        end
        if (load_out)
        begin
            out_found_reg   <= load_found;
            out_seed_reg    <= load_seed;
            out_earlier_reg <= load_earlier;
            out_last_reg    <= load_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = out_found_reg;
    assign result.seed_value   = out_seed_reg;
    assign result.earlier_seed = out_earlier_reg;
    assign result.last         = out_last_reg;

endmodule

[sim/lcg_seed_preimage_search_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// LCG seed preimage search: regression testbench
// Sends search transactions and predicts their results with a behavioral scan.
// The prediction tries all 65536 candidate seeds and rewinds each match. Every
// result transaction is checked field by field against the oldest prediction.
// ============================================================================
module lcg_seed_preimage_search_tb;
    import lspe_pkg::*;

    // One predicted or observed result transaction.
    typedef struct packed {
        logic        found;
        logic [31:0] seed_value;
        logic [31:0] earlier_seed;
        logic        last;
    } preimage_t;

    localparam int SCAN_SIZE     = 65536;
    localparam int MAX_MATCHES   = 4;
    localparam int PHASE_ITEMS   = 20;
    // Cycles allowed after the final result for any stray output to show up.
    // This is roughly the rewind time of one match at a moderate back_steps.
    localparam int SETTLE_CYCLES = 2000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        back_steps_we;
    logic [11:0] back_steps_wdata;

    lspe_in_if  search_if ();
    lspe_out_if result_if ();

    lcg_seed_preimage_search u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .back_steps_we    (back_steps_we),
        .back_steps_wdata (back_steps_wdata),
        .search           (search_if),
        .result           (result_if)
    );

    // The testbench keeps its own copy of the back_steps register. It changes
    // only while the block is idle, so each prediction can use it directly.
    logic [11:0] model_back_steps;
    preimage_t   expected_preimages[$];

    // Idling control: percent chance of a sender gap or a receiver stall per cycle.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    int unsigned searches_sent;
    int unsigned results_seen;
    int unsigned seeds_found;
    int unsigned empty_scans;
    int unsigned error_count;

    always #1 clk = ~clk;

    // One forward step of the generator. The multiply-add wraps at 32 bits.
    function automatic logic [31:0] lcg_next(input logic [31:0] x);
        return x * FWD_MUL + FWD_ADD;
    endfunction

    // Predict the results of one accepted search transaction. All lower halves
    // are scanned in increasing order. Each seed whose successor has the wanted
    // upper half is kept and stepped back model_back_steps times. A scan with
    // no match still yields one result. That result has found clear, zero
    // seeds and last set.
    function automatic void predict_preimages(input logic [15:0] first_high,
                                              input logic [15:0] next_high);
        preimage_t   hits[$];
        preimage_t   hit;
        logic [31:0] seed;
        logic [31:0] state;
        logic [31:0] back;
        for (int lo = 0; lo < SCAN_SIZE; lo++)
        begin
            seed  = {first_high, lo[15:0]};
            state = lcg_next(seed);
            if (state[31:16] == next_high && hits.size() < MAX_MATCHES)
            begin
                back = seed;
                for (int k = 0; k < int'(model_back_steps); k++)
                    back = back * INV_MUL + INV_ADD;
                hit = '{found: 1'b1, seed_value: seed, earlier_seed: back, last: 1'b0};
                hits.push_back(hit);
            end
        end
        if (hits.size() == 0)
        begin
            hit = '{found: 1'b0, seed_value: '0, earlier_seed: '0, last: 1'b1};
            hits.push_back(hit);
        end
        else
        begin
            hit = hits[hits.size() - 1];
            hit.last = 1'b1;
            hits[hits.size() - 1] = hit;
        end
        foreach (hits[i])
            expected_preimages.push_back(hits[i]);
    endfunction

    // Find a next_high that exactly the given number of seeds under
    // first_high lead to. Returns 0 when no such value exists.
    function automatic bit find_next_high(input logic [15:0] first_high, input int count,
                                          output logic [15:0] pick);
        byte unsigned tally [SCAN_SIZE];
        logic [31:0]  state;
        foreach (tally[i])
            tally[i] = 0;
        for (int lo = 0; lo < SCAN_SIZE; lo++)
        begin
            state = lcg_next({first_high, lo[15:0]});
            tally[state[31:16]]++;
        end
        for (int v = 0; v < SCAN_SIZE; v++)
        begin
            if (int'(tally[v]) == count)
            begin
                pick = v[15:0];
                return 1'b1;
            end
        end
        pick = '0;
        return 1'b0;
    endfunction

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        error_count++;
        $display("%0t ns: %s mismatch, expected %08h, actual %08h", $time, field, want, got);
    endfunction

    // Offer one search transaction and wait until the block accepts it. The
    // sender may idle first. valid stays high after acceptance. This lets
    // back-to-back transactions run without lowering and raising valid in one
    // time step. Gaps and waits lower it explicitly.
    task automatic send_search(input logic [15:0] first_high, input logic [15:0] next_high);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            search_if.valid <= 1'b0;
            @(posedge clk);
        end
        search_if.valid      <= 1'b1;
        search_if.first_high <= first_high;
        search_if.next_high  <= next_high;
        @(posedge clk);
        while (!search_if.ready)
            @(posedge clk);
        predict_preimages(first_high, next_high);
        searches_sent++;
    endtask

    // Search for the pair that a known seed produces, so at least that seed matches.
    task automatic send_seed(input logic [31:0] seed);
        logic [31:0] state;
        state = lcg_next(seed);
        send_search(seed[31:16], state[31:16]);
    endtask

    // Send a search that yields exactly the given number of matching seeds.
    // A few upper halves are tried until one has a suitable next_high.
    task automatic send_with_matches(input int count);
        logic [15:0] first_high;
        logic [15:0] next_high;
        for (int attempt = 0; attempt < 16; attempt++)
        begin
            first_high = 16'($urandom_range(16'hFFFF));
            if (find_next_high(first_high, count, next_high))
            begin
                send_search(first_high, next_high);
                return;
            end
        end
    endtask

    // Park the sender and wait until every predicted result has been checked.
    task automatic wait_for_results();
        search_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_preimages.size() != 0)
            @(posedge clk);
    endtask

    // back_steps is written only once the block has drained.
    task automatic write_back_steps(input logic [11:0] value);
        wait_for_results();
        back_steps_we    <= 1'b1;
        back_steps_wdata <= value;
        @(posedge clk);
        back_steps_we    <= 1'b0;
        model_back_steps = value;
    endtask

    // With back_steps at its reset value, check the first and last candidates of
    // a scan and the extreme values of both search fields.
    task automatic test_scan_edges();
        logic [31:0] seed;
        send_seed(32'h0000_0000);
        send_seed(32'hFFFF_FFFF);
        seed = $urandom;
        send_seed({seed[31:16], 16'h0000});
        seed = $urandom;
        send_seed({seed[31:16], 16'hFFFF});
        send_search(16'h0000, 16'h0000);
        send_search(16'h0000, 16'hFFFF);
        send_search(16'hFFFF, 16'h0000);
        send_search(16'hFFFF, 16'hFFFF);
    endtask

    // Check each possible number of matches, from an empty scan to four seeds.
    task automatic test_match_counts();
        for (int count = 0; count <= MAX_MATCHES; count++)
            send_with_matches(count);
        send_with_matches(0);
    endtask

    // Check the range of back_steps. With zero steps, earlier_seed must equal the
    // seed. At the maximum, each of four matches gets the longest rewind.
    task automatic test_back_steps_range();
        write_back_steps(12'd0);
        send_seed($urandom);
        send_with_matches(MAX_MATCHES);
        write_back_steps(12'd4095);
        send_with_matches(MAX_MATCHES);
        send_seed($urandom);
        write_back_steps(12'd1);
        send_seed($urandom);
    endtask

    // Random searches in four idling phases, each with its own back_steps.
    // Most searches come from a random seed, so they are sure to reach the
    // rewind engine. The rest are random pairs that often find nothing.
    task automatic test_random_searches();
        int unsigned idle_pct  [4] = '{0, 69, 0, 16};
        int unsigned stall_pct [4] = '{0, 0, 69, 16};
        logic [11:0] steps     [4];
        steps[0] = 12'($urandom_range(12'hFFF));
        steps[1] = 12'd0;
        steps[2] = 12'd4095;
        steps[3] = BACK_STEPS_RESET;
        for (int p = 0; p < 4; p++)
        begin
            write_back_steps(steps[p]);
            sender_idle_pct    = idle_pct[p];
            receiver_stall_pct = stall_pct[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(3) != 0)
                    send_seed($urandom);
                else
                    send_search(16'($urandom_range(16'hFFFF)),
                                16'($urandom_range(16'hFFFF)));
                // Midway through the first phase, hold the sender off until the
                // block has fully drained.
                if (p == 0 && n == PHASE_ITEMS / 2)
                    wait_for_results();
            end
        end
    endtask

    // Result side. ready is redrawn every cycle from the current stall rate.
    // Each accepted result transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        preimage_t got;
        preimage_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = '{found: result_if.found, seed_value: result_if.seed_value,
                    earlier_seed: result_if.earlier_seed, last: result_if.last};
            results_seen++;
            if (got.found)
                seeds_found++;
            else
                empty_scans++;
            if (expected_preimages.size() == 0)
            begin
                error_count++;
                $display("%0t ns: result with nothing expected, found %0b seed %08h",
                         $time, got.found, got.seed_value);
                $display("    earlier %08h last %0b", got.earlier_seed, got.last);
            end
            else
            begin
                want = expected_preimages.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 32'(want.found), 32'(got.found));
                if (got.seed_value !== want.seed_value)
                    report_mismatch("seed_value", want.seed_value, got.seed_value);
                if (got.earlier_seed !== want.earlier_seed)
                    report_mismatch("earlier_seed", want.earlier_seed, got.earlier_seed);
                if (got.last !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(got.last));
            end
        end
        result_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial
    begin
        rst_n                <= 1'b0;
        back_steps_we        <= 1'b0;
        back_steps_wdata     <= '0;
        search_if.valid      <= 1'b0;
        search_if.first_high <= '0;
        search_if.next_high  <= '0;
        model_back_steps   = BACK_STEPS_RESET;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        searches_sent      = 0;
        results_seen       = 0;
        seeds_found        = 0;
        empty_scans        = 0;
        error_count        = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scan_edges();
        test_match_counts();
        test_back_steps_range();
        test_random_searches();

        // Drain, then leave time for any extra result to appear.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d search transactions and checked %0d results (%0d seeds, %0d empty).",
                 searches_sent, results_seen, seeds_found, empty_scans);
        $display("back_steps covered 0, 1, 1100, 4095 and a random value, with gaps and stalls.");
        if (error_count == 0)
            $display("lcg_seed_preimage_search regression: pass");
        else
            $display("lcg_seed_preimage_search regression: fail");
        $finish;
    end

    // A correct run takes about 100 scans. At 2 ns per cycle the whole run
    // stays under about 17 ms even with the longest rewinds, so 200 ms is ample.
    initial
    begin
        #200_000_000;
        $display("lcg_seed_preimage_search regression: fail");
        $finish;
    end

endmodule

[lcg_seed_preimage_search.f]
hw/rtl/lspe_pkg.sv
hw/rtl/lspe_if.sv
hw/rtl/lspe_fifo.sv
hw/rtl/lspe_front.sv
hw/rtl/lspe_back.sv
hw/rtl/lcg_seed_preimage_search.sv
sim/lcg_seed_preimage_search_tb.sv
